// ===== rtl/core/vmsg_pkg.sv =====
// Shared types and constants for the von Mises stress and gradient unit.
package vmsg_pkg;

  typedef enum logic [1:0] {
    LAYOUT_PLANE_STRESS = 2'd0,
    LAYOUT_PLANE_STRAIN = 2'd1,
    LAYOUT_SOLID        = 2'd2
  } layout_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int GUARD_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_LAYOUT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRAD_EN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GUARD   = 2'd2;

  localparam logic [GUARD_W-1:0] GUARD_RESET = 16'd1;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== rtl/core/vmsg_front.sv =====
// Front end: accepts input beats and maps the stress layout onto uniform operands.
module vmsg_front #(
  parameter int DATA_WIDTH = 32,
  parameter int ENTRY_W    = 12 * DATA_WIDTH + 6
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DATA_WIDTH-1:0]  stress [6],
  input  logic signed [DATA_WIDTH-1:0]  deriv [6],
  input  vmsg_pkg::layout_t             layout,
  input  vmsg_pkg::fifo_status_t        q_status,
  output logic                          push,
  output logic [ENTRY_W-1:0]            push_data
);

  localparam int XW = DATA_WIDTH + 1;

  logic signed [XW-1:0] sx [3];
  logic signed [XW-1:0] dx [3];
  logic signed [XW-1:0] xv [3];
  logic signed [XW-1:0] yv [3];
  logic signed [DATA_WIDTH-1:0] zv [3];
  logic signed [DATA_WIDTH-1:0] wv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sx[k] = XW'(stress[k]);
      dx[k] = XW'(deriv[k]);
    end
    xv[0] = sx[0] - sx[1];
    yv[0] = dx[0] - dx[1];
    case (layout)
      vmsg_pkg::LAYOUT_PLANE_STRESS: begin
        xv[1] = sx[1];
        yv[1] = dx[1];
        xv[2] = sx[0];
        yv[2] = dx[0];
        zv[0] = stress[2];
        wv[0] = deriv[2];
        zv[1] = '0;
        wv[1] = '0;
        zv[2] = '0;
        wv[2] = '0;
      end
      vmsg_pkg::LAYOUT_PLANE_STRAIN: begin
        xv[1] = sx[1] - sx[2];
        yv[1] = dx[1] - dx[2];
        xv[2] = sx[2] - sx[0];
        yv[2] = dx[2] - dx[0];
        zv[0] = stress[3];
        wv[0] = deriv[3];
        zv[1] = '0;
        wv[1] = '0;
        zv[2] = '0;
        wv[2] = '0;
      end
      default: begin
        xv[1] = sx[1] - sx[2];
        yv[1] = dx[1] - dx[2];
        xv[2] = sx[2] - sx[0];
        yv[2] = dx[2] - dx[0];
        zv[0] = stress[3];
        wv[0] = deriv[3];
        zv[1] = stress[4];
        wv[1] = deriv[4];
        zv[2] = stress[5];
        wv[2] = deriv[5];
      end
    endcase
  end

  assign push_data = {xv[0], xv[1], xv[2], yv[0], yv[1], yv[2],
                      zv[0], zv[1], zv[2], wv[0], wv[1], wv[2]};
  assign in_stall  = q_status.full;
  assign push      = in_valid && !q_status.full;

endmodule

// ===== rtl/core/vmsg_queue.sv =====
// Short queue that decouples the front end from the arithmetic back end.
module vmsg_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        push_data,
  input  logic                    pop,
  output logic [WIDTH-1:0]        pop_data,
  output vmsg_pkg::fifo_status_t  status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data     = mem[rd_ptr];
  assign status.full  = (count == FULL_COUNT);
  assign status.empty = (count == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("Queue count exceeds its depth.");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("Queue count did not drop on a pop.");
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("Queue count did not rise on a push.");

endmodule

// ===== rtl/core/vmsg_back.sv =====
// Back end: squares, sums, pipelined square root and division, output register.
module vmsg_back #(
  parameter int DATA_WIDTH = 32,
  parameter int ENTRY_W    = 12 * DATA_WIDTH + 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vmsg_pkg::fifo_status_t              q_status,
  input  logic [ENTRY_W-1:0]                  q_data,
  output logic                                q_pop,
  input  logic                                grad_en,
  input  logic [vmsg_pkg::GUARD_W-1:0]        guard,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [DATA_WIDTH-1:0]               equivalent_stress,
  output logic signed [DATA_WIDTH-1:0]        stress_gradient,
  output logic                                saturated
);

  localparam int D    = DATA_WIDTH;
  localparam int XW   = D + 1;
  localparam int GSW  = 2 * D + 4;
  localparam int GW   = GSW - 1;
  localparam int VW   = D + 1;
  localparam int QW   = 2 * VW;
  localparam int DVW  = D + 2;
  localparam int DIVW = D + 3;

  logic adv;
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_status.empty;

  logic signed [XW-1:0] xv [3];
  logic signed [XW-1:0] yv [3];
  logic signed [D-1:0]  zv [3];
  logic signed [D-1:0]  wv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xv[k] = q_data[ENTRY_W-1-k*XW -: XW];
      yv[k] = q_data[ENTRY_W-1-(3+k)*XW -: XW];
      zv[k] = q_data[6*D-1-k*D -: D];
      wv[k] = q_data[3*D-1-k*D -: D];
    end
  end

  logic                     p1_v;
  logic signed [2*XW-1:0]   xx [3];
  logic signed [2*XW-1:0]   xy [3];
  logic signed [2*D-1:0]    zz [3];
  logic signed [2*D-1:0]    wz [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        xx[k] <= xv[k] * xv[k];
        xy[k] <= xv[k] * yv[k];
        zz[k] <= zv[k] * zv[k];
        wz[k] <= zv[k] * wv[k];
      end
    end
  end

  logic                   p2_v;
  logic signed [GSW-1:0]  n2;
  logic signed [GSW-1:0]  s2;
  logic signed [GSW-1:0]  gxy2;
  logic signed [GSW-1:0]  gwz2;

  always_ff @(posedge clk) begin
    if (adv) begin
      n2   <= GSW'(xx[0]) + GSW'(xx[1]) + GSW'(xx[2]);
      s2   <= GSW'(zz[0]) + GSW'(zz[1]) + GSW'(zz[2]);
      gxy2 <= GSW'(xy[0]) + GSW'(xy[1]) + GSW'(xy[2]);
      gwz2 <= GSW'(wz[0]) + GSW'(wz[1]) + GSW'(wz[2]);
    end
  end

  logic signed [GSW-1:0] q2;
  logic signed [GSW-1:0] g2;
  logic signed [GSW-1:0] gabs;
  assign q2   = n2 + (s2 <<< 2) + (s2 <<< 1);
  assign g2   = gxy2 + (gwz2 <<< 2) + (gwz2 <<< 1);
  assign gabs = g2[GSW-1] ? -g2 : g2;

  logic            sq_v    [VW+1];
  logic [QW-1:0]   sq_rad  [VW+1];
  logic [VW-1:0]   sq_root [VW+1];
  logic [VW:0]     sq_rem  [VW+1];
  logic [GW-1:0]   sq_g    [VW+1];
  logic            sq_neg  [VW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rad[0]  <= q2[QW:1];
      sq_root[0] <= '0;
      sq_rem[0]  <= '0;
      sq_g[0]    <= gabs[GW-1:0];
      sq_neg[0]  <= g2[GSW-1];
    end
  end

  for (genvar i = 0; i < VW; i++) begin : g_sqrt
    logic [VW+2:0] cur;
    logic [VW+2:0] trial;
    logic          ge;
    assign cur   = {sq_rem[i], sq_rad[i][QW-1 -: 2]};
    assign trial = {1'b0, sq_root[i], 2'b01};
    assign ge    = (cur >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[i+1]  <= ge ? (VW+1)'(cur - trial) : (VW+1)'(cur);
        sq_root[i+1] <= {sq_root[i][VW-2:0], ge};
        sq_rad[i+1]  <= {sq_rad[i][QW-3:0], 2'b00};
        sq_g[i+1]    <= sq_g[i];
        sq_neg[i+1]  <= sq_neg[i];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i+1] <= 1'b0;
      end else if (adv) begin
        sq_v[i+1] <= sq_v[i];
      end
    end
  end

  logic [DVW-1:0] vme;
  logic [DVW-1:0] gde;
  logic [DVW-1:0] divisor;
  assign vme     = DVW'(sq_root[VW]);
  assign gde     = DVW'(guard);
  assign divisor = (vme < gde) ? gde + vme : vme;

  logic            dv_v   [GW+1];
  logic [GW-1:0]   dv_num [GW+1];
  logic [DIVW-1:0] dv_rem [GW+1];
  logic [DIVW-1:0] dv_d   [GW+1];
  logic [VW-1:0]   dv_vm  [GW+1];
  logic            dv_neg [GW+1];
  logic            dv_act [GW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_num[0] <= sq_g[VW];
      dv_rem[0] <= '0;
      dv_d[0]   <= {divisor, 1'b0};
      dv_vm[0]  <= sq_root[VW];
      dv_neg[0] <= sq_neg[VW];
      dv_act[0] <= grad_en && (divisor != '0);
    end
  end

  for (genvar i = 0; i < GW; i++) begin : g_div
    logic [DIVW:0] cur;
    logic [DIVW:0] dext;
    logic          ge;
    assign cur  = {dv_rem[i], dv_num[i][GW-1]};
    assign dext = {1'b0, dv_d[i]};
    assign ge   = (cur >= dext);
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[i+1] <= ge ? DIVW'(cur - dext) : DIVW'(cur);
        dv_num[i+1] <= {dv_num[i][GW-2:0], ge};
        dv_d[i+1]   <= dv_d[i];
        dv_vm[i+1]  <= dv_vm[i];
        dv_neg[i+1] <= dv_neg[i];
        dv_act[i+1] <= dv_act[i];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (adv) begin
        dv_v[i+1] <= dv_v[i];
      end
    end
  end

  logic [D-1:0]  limit;
  logic          over;
  logic [D-1:0]  mq;
  logic [D-1:0]  grad_val;
  logic [D-1:0]  eq_val;
  logic          sat_val;
  logic [VW-1:0] vm_last;

  assign vm_last  = dv_vm[GW];
  assign limit    = {1'b1, {(D-1){1'b0}}} - D'(!dv_neg[GW]);
  assign over     = dv_num[GW] > GW'(limit);
  assign mq       = over ? limit : dv_num[GW][D-1:0];
  assign grad_val = !dv_act[GW] ? '0 : (dv_neg[GW] ? -mq : mq);
  assign eq_val   = vm_last[D] ? '1 : vm_last[D-1:0];
  assign sat_val  = vm_last[D] || (dv_act[GW] && over);

  always_ff @(posedge clk) begin
    if (adv) begin
      equivalent_stress <= eq_val;
      stress_gradient   <= grad_val;
      saturated         <= sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      sq_v[0]   <= 1'b0;
      dv_v[0]   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1_v      <= !q_status.empty;
      p2_v      <= p1_v;
      sq_v[0]   <= p2_v;
      dv_v[0]   <= sq_v[VW];
      out_valid <= dv_v[GW];
    end
  end

endmodule

// ===== rtl/core/von_mises_stress_with_gradient_unit.sv =====
// Top level of the von Mises equivalent stress and gradient unit.
//
// Input beats carry six stress components and six derivative entries, all
// signed fixed point. A beat is taken when in_valid is high and in_stall low.
// Each beat gives one output beat with the equivalent stress, the gradient
// entry and a saturation flag, in the order the inputs were taken.
// Configuration writes use cfg_valid and cfg_ready with a register index and
// data; the user must make them while the unit is idle, which the unit does
// not enforce. cfg_ready is always high. Throughput is one beat per cycle
// while out_stall does not hold the back pipeline. An input beat passes the
// queue, the product and sum registers, the square root stages, the divisor
// register and the division stages, then the output register.
// While an output beat waits under out_stall the whole back pipeline holds;
// the four-entry queue then fills and in_stall rises once it is full.
// Reset clears the pipeline, the queue and the registers to solid layout,
// gradient enabled and a guard of one.
module von_mises_stress_with_gradient_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [DATA_WIDTH-1:0]          stress_0,
  input  logic signed [DATA_WIDTH-1:0]          stress_1,
  input  logic signed [DATA_WIDTH-1:0]          stress_2,
  input  logic signed [DATA_WIDTH-1:0]          stress_3,
  input  logic signed [DATA_WIDTH-1:0]          stress_4,
  input  logic signed [DATA_WIDTH-1:0]          stress_5,
  input  logic signed [DATA_WIDTH-1:0]          deriv_0,
  input  logic signed [DATA_WIDTH-1:0]          deriv_1,
  input  logic signed [DATA_WIDTH-1:0]          deriv_2,
  input  logic signed [DATA_WIDTH-1:0]          deriv_3,
  input  logic signed [DATA_WIDTH-1:0]          deriv_4,
  input  logic signed [DATA_WIDTH-1:0]          deriv_5,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [DATA_WIDTH-1:0]                 equivalent_stress,
  output logic signed [DATA_WIDTH-1:0]          stress_gradient,
  output logic                                  saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vmsg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [vmsg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int ENTRY_W = 12 * DATA_WIDTH + 6;

  vmsg_pkg::layout_t             layout;
  logic                          grad_en;
  logic [vmsg_pkg::GUARD_W-1:0]  guard;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout  <= vmsg_pkg::LAYOUT_SOLID;
      grad_en <= 1'b1;
      guard   <= vmsg_pkg::GUARD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vmsg_pkg::CFG_LAYOUT:  layout  <= vmsg_pkg::layout_t'(cfg_data[1:0]);
        vmsg_pkg::CFG_GRAD_EN: grad_en <= cfg_data[0];
        vmsg_pkg::CFG_GUARD:   guard   <= cfg_data[vmsg_pkg::GUARD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic signed [DATA_WIDTH-1:0] stress [6];
  logic signed [DATA_WIDTH-1:0] deriv [6];

  assign stress[0] = stress_0;
  assign stress[1] = stress_1;
  assign stress[2] = stress_2;
  assign stress[3] = stress_3;
  assign stress[4] = stress_4;
  assign stress[5] = stress_5;
  assign deriv[0]  = deriv_0;
  assign deriv[1]  = deriv_1;
  assign deriv[2]  = deriv_2;
  assign deriv[3]  = deriv_3;
  assign deriv[4]  = deriv_4;
  assign deriv[5]  = deriv_5;

  vmsg_pkg::fifo_status_t  q_status;
  logic                    push;
  logic                    pop;
  logic [ENTRY_W-1:0]      push_data;
  logic [ENTRY_W-1:0]      pop_data;

  vmsg_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .stress    (stress),
    .deriv     (deriv),
    .layout    (layout),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  vmsg_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (vmsg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  vmsg_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_status          (q_status),
    .q_data            (pop_data),
    .q_pop             (pop),
    .grad_en           (grad_en),
    .guard             (guard),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .equivalent_stress (equivalent_stress),
    .stress_gradient   (stress_gradient),
    .saturated         (saturated)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the von Mises stress and gradient unit.
module tb;

  localparam int DW = 32;
  localparam int CDW = vmsg_pkg::CFG_DATA_W;
  localparam int LATENCY = 3 * DW + 10;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [DW-1:0] s[6];
    logic signed [DW-1:0] d[6];
  } load_t;

  typedef struct {
    logic [DW-1:0] eq;
    logic [DW-1:0] grad;
    logic          sat;
  } vm_result_t;

  class stress_scoreboard;
    logic [1:0]                   layout;
    logic                         grad_en;
    logic [vmsg_pkg::GUARD_W-1:0] guard;
    vm_result_t                   pending_results[$];
    int                           errors;

    function new();
      layout = vmsg_pkg::LAYOUT_SOLID;
      grad_en = 1'b1;
      guard = vmsg_pkg::GUARD_RESET;
      errors = 0;
    endfunction

    function void configure(logic [vmsg_pkg::CFG_INDEX_W-1:0] idx,
                            logic [vmsg_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        vmsg_pkg::CFG_LAYOUT:  layout = data[1:0];
        vmsg_pkg::CFG_GRAD_EN: grad_en = data[0];
        vmsg_pkg::CFG_GUARD:   guard = data[vmsg_pkg::GUARD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_load(load_t it);
      logic signed [127:0] sv[6], dv[6];
      logic signed [127:0] a, b, c, sumsq, gsum;
      logic [127:0]        half, root, cand, divisor, mg, qt, lim;
      int                  first, nsh;
      vm_result_t          r;
      for (int i = 0; i < 6; i++) begin
        sv[i] = 128'(it.s[i]);
        dv[i] = 128'(it.d[i]);
      end
      a = sv[0] - sv[1];
      if (layout == vmsg_pkg::LAYOUT_PLANE_STRESS) begin
        sumsq = a * a + sv[1] * sv[1] + sv[0] * sv[0];
        gsum = dv[0] * a - dv[1] * a + dv[1] * sv[1] + dv[0] * sv[0];
        first = 2;
        nsh = 1;
      end else begin
        b = sv[1] - sv[2];
        c = sv[2] - sv[0];
        sumsq = a * a + b * b + c * c;
        gsum = dv[0] * a - dv[1] * a + dv[1] * b - dv[2] * b + dv[2] * c - dv[0] * c;
        first = 3;
        nsh = (layout == vmsg_pkg::LAYOUT_PLANE_STRAIN) ? 1 : 3;
      end
      for (int i = first; i < first + nsh; i++) begin
        sumsq += 6 * sv[i] * sv[i];
        gsum += 6 * dv[i] * sv[i];
      end
      half = sumsq >> 1;
      root = 0;
      for (int bit_i = 52; bit_i >= 0; bit_i--) begin
        cand = root | (128'd1 << bit_i);
        if (cand * cand <= half) root = cand;
      end
      r.sat = 1'b0;
      r.grad = '0;
      if (root > 128'hFFFF_FFFF) begin
        r.eq = '1;
        r.sat = 1'b1;
      end else begin
        r.eq = root[DW-1:0];
      end
      if (grad_en) begin
        divisor = (root < guard) ? root + guard : root;
        if (divisor != 0) begin
          mg = (gsum < 0) ? -gsum : gsum;
          qt = mg / (2 * divisor);
          lim = (gsum < 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
          if (qt > lim) begin
            qt = lim;
            r.sat = 1'b1;
          end
          r.grad = (gsum < 0) ? -qt[DW-1:0] : qt[DW-1:0];
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [DW-1:0] eq, logic [DW-1:0] grad, logic sat);
      vm_result_t x;
      if (pending_results.size() == 0) begin
        $error("output beat with no input outstanding");
        errors++;
        return;
      end
      x = pending_results.pop_front();
      if (eq !== x.eq) begin
        $error("equivalent_stress expected %h actual %h", x.eq, eq);
        errors++;
      end
      if (grad !== x.grad) begin
        $error("stress_gradient expected %h actual %h", x.grad, grad);
        errors++;
      end
      if (sat !== x.sat) begin
        $error("saturated expected %b actual %b", x.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, saturated;
  logic signed [DW-1:0] stress_0, stress_1, stress_2, stress_3, stress_4, stress_5;
  logic signed [DW-1:0] deriv_0, deriv_1, deriv_2, deriv_3, deriv_4, deriv_5;
  logic [DW-1:0] equivalent_stress;
  logic signed [DW-1:0] stress_gradient;
  logic cfg_valid, cfg_ready;
  logic [vmsg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [vmsg_pkg::CFG_DATA_W-1:0] cfg_data;

  stress_scoreboard sb = new();
  bit busy_mode;
  bit hold_request;
  int idle_cycles;

  von_mises_stress_with_gradient_unit #(.DATA_WIDTH(DW)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .stress_0(stress_0), .stress_1(stress_1), .stress_2(stress_2),
    .stress_3(stress_3), .stress_4(stress_4), .stress_5(stress_5),
    .deriv_0(deriv_0), .deriv_1(deriv_1), .deriv_2(deriv_2),
    .deriv_3(deriv_3), .deriv_4(deriv_4), .deriv_5(deriv_5),
    .out_valid(out_valid), .out_stall(out_stall),
    .equivalent_stress(equivalent_stress), .stress_gradient(stress_gradient),
    .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_load('{s: '{stress_0, stress_1, stress_2, stress_3, stress_4, stress_5},
                       d: '{deriv_0, deriv_1, deriv_2, deriv_3, deriv_4, deriv_5}});
      if (out_valid && !out_stall)
        sb.check_result(equivalent_stress, stress_gradient, saturated);
      if (cfg_valid && cfg_ready)
        sb.configure(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[von_mises_stress_with_gradient_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, with one long hold-off to back up the queue.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk) out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (busy_mode || $urandom_range(0, 9) < 6) begin
        @(negedge clk) out_stall <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send_load(load_t it);
    int gap;
    gap = busy_mode ? 0 :
          ($urandom_range(0, 9) < 6 ? 0 :
           ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
    @(negedge clk);
    {stress_0, stress_1, stress_2, stress_3, stress_4, stress_5} <=
      {it.s[0], it.s[1], it.s[2], it.s[3], it.s[4], it.s[5]};
    {deriv_0, deriv_1, deriv_2, deriv_3, deriv_4, deriv_5} <=
      {it.d[0], it.d[1], it.d[2], it.d[3], it.d[4], it.d[5]};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [vmsg_pkg::CFG_INDEX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CDW'(data);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [DW-1:0] pick_word(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 131071)) - 65536;
      2: case ($urandom_range(0, 3))
           0: return 32'sh8000_0000;
           1: return 32'sh7FFF_FFFF;
           2: return 0;
           default: return -1;
         endcase
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  function automatic load_t random_load();
    load_t it;
    int mode;
    logic signed [DW-1:0] base;
    mode = $urandom_range(0, 9);
    base = $urandom;
    for (int i = 0; i < 6; i++) begin
      if (mode < 4) begin
        it.s[i] = pick_word(0);
        it.d[i] = pick_word(0);
      end else if (mode < 6) begin
        it.s[i] = pick_word(1);
        it.d[i] = pick_word($urandom_range(0, 1));
      end else if (mode < 8) begin
        it.s[i] = pick_word($urandom_range(0, 2));
        it.d[i] = pick_word($urandom_range(0, 2));
      end else begin
        it.s[i] = (i < 3) ? base + pick_word(3) : pick_word(3);
        it.d[i] = pick_word($urandom_range(0, 1));
      end
    end
    return it;
  endfunction

  function automatic load_t fill_load(logic signed [DW-1:0] sval, logic signed [DW-1:0] dval);
    load_t it;
    for (int i = 0; i < 6; i++) begin
      it.s[i] = sval;
      it.d[i] = dval;
    end
    return it;
  endfunction

  initial begin
    load_t it;
    logic [1:0] lay;
    rst = 1'b1;
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {stress_0, stress_1, stress_2, stress_3, stress_4, stress_5} = '0;
    {deriv_0, deriv_1, deriv_2, deriv_3, deriv_4, deriv_5} = '0;
    busy_mode = 1'b0;
    hold_request = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed beats at reset settings and in each layout.
    for (int k = 0; k < 4; k++) begin
      if (k > 0) begin
        drain();
        write_reg(vmsg_pkg::CFG_LAYOUT, k - 1);
      end
      send_load(fill_load(0, 0));
      send_load(fill_load(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      it = fill_load(0, 32'sh8000_0000);
      it.s[0] = 32'sh7FFF_FFFF;
      it.s[1] = 32'sh8000_0000;
      send_load(it);
      it = fill_load(0, 32'sh7FFF_FFFF);
      it.s[0] = 1;
      send_load(it);
      it = fill_load(0, 32'sh8000_0000);
      it.s[3] = 32'sh8000_0000;
      it.s[2] = 32'sh8000_0000;
      send_load(it);
      send_load(fill_load(32'sh0001_0000, 32'sh0001_0000));
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin write_reg(vmsg_pkg::CFG_LAYOUT, int'(vmsg_pkg::LAYOUT_SOLID));
                 write_reg(vmsg_pkg::CFG_GRAD_EN, 1);
                 write_reg(vmsg_pkg::CFG_GUARD, 'hFFFF); end
        1: begin write_reg(vmsg_pkg::CFG_LAYOUT, int'(vmsg_pkg::LAYOUT_PLANE_STRESS));
                 write_reg(vmsg_pkg::CFG_GUARD, 1); end
        2: begin write_reg(vmsg_pkg::CFG_LAYOUT, int'(vmsg_pkg::LAYOUT_PLANE_STRAIN));
                 write_reg(vmsg_pkg::CFG_GRAD_EN, 0); end
        3: begin write_reg(vmsg_pkg::CFG_LAYOUT, 3); write_reg(vmsg_pkg::CFG_GRAD_EN, 1);
                 write_reg(vmsg_pkg::CFG_GUARD, 0); end
        4: begin write_reg(vmsg_pkg::CFG_LAYOUT, int'(vmsg_pkg::LAYOUT_PLANE_STRESS));
                 write_reg(vmsg_pkg::CFG_GUARD, 'hFFFF); end
        default: begin
          lay = 2'($urandom_range(0, 3));
          write_reg(vmsg_pkg::CFG_LAYOUT, int'(lay));
          write_reg(vmsg_pkg::CFG_GRAD_EN, int'($urandom_range(0, 1)));
          write_reg(vmsg_pkg::CFG_GUARD, int'($urandom));
        end
      endcase
      busy_mode = (ph == 0) || ($urandom_range(0, 3) == 0);
      if (ph == 0) hold_request = 1'b1;
      for (int n = 0; n < 140; n++) send_load(random_load());
    end

    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("[von_mises_stress_with_gradient_unit] OK");
    else
      $display("[von_mises_stress_with_gradient_unit] ERROR");
    $finish;
  end
endmodule
